>>> rtl/tcphp_pkg.sv
// ----------------------------------------------------------------------------
// tcphp_pkg
// Shared constants and types for the TCP header parser and checksum block.
// ----------------------------------------------------------------------------
package tcphp_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int HDR_BYTES       = 20;
  localparam int CSUM_POS_HI     = 16;  // checksum bytes are left out of the sum
  localparam int CSUM_POS_LO     = 17;

  typedef logic [HDR_BYTES-1:0][7:0] hdr_t;

  typedef struct packed {
    logic        header_ok;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [7:0]  flag_bits;
    logic [15:0] window_size;
    logic [15:0] received_sum;
    logic [15:0] computed_sum;
    logic        sum_match;
    logic [15:0] payload_bytes;
  } res_t;

endpackage

>>> rtl/tcphp_if.sv
// ----------------------------------------------------------------------------
// tcphp_in_if / tcphp_out_if
// Valid/ready channels for segment bytes and parse results.
// ----------------------------------------------------------------------------
interface tcphp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        last_byte;
  logic [31:0] pseudo_sum;

  modport source (output valid, data_byte, first_byte, last_byte, pseudo_sum,
                  input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, pseudo_sum,
                  output ready);
endinterface

interface tcphp_out_if;
  logic        valid;
  logic        ready;
  logic        header_ok;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [31:0] seq_number;
  logic [31:0] ack_number;
  logic [7:0]  flag_bits;
  logic [15:0] window_size;
  logic [15:0] received_sum;
  logic [15:0] computed_sum;
  logic        sum_match;
  logic [15:0] payload_bytes;

  modport source (output valid, header_ok, source_port, dest_port, seq_number,
                  ack_number, flag_bits, window_size, received_sum,
                  computed_sum, sum_match, payload_bytes,
                  input ready);
  modport sink   (input valid, header_ok, source_port, dest_port, seq_number,
                  ack_number, flag_bits, window_size, received_sum,
                  computed_sum, sum_match, payload_bytes,
                  output ready);
endinterface

>>> rtl/tcphp_result.sv
// ----------------------------------------------------------------------------
// tcphp_result
// Folds the segment sum, inverts it and lays out the header fields of one
// finished segment. Short segments give an all-zero result.
// ----------------------------------------------------------------------------
module tcphp_result #(
  parameter int LENGTH_BITS = tcphp_pkg::LENGTH_BITS_DEF
) (
  input  logic [31:0]            sum_acc,
  input  logic [LENGTH_BITS-1:0] total,
  input  tcphp_pkg::hdr_t        hdr,
  output tcphp_pkg::res_t        res
);

  localparam int PW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

  logic [16:0]   fold1;
  logic [16:0]   fold2;
  logic [15:0]   calc;
  logic [15:0]   rx;
  logic [PW-1:0] pay_w;
  logic          long_enough;

  always_comb begin
    // two folds bring any 32-bit sum down to 16 bits
    fold1       = {1'b0, sum_acc[31:16]} + {1'b0, sum_acc[15:0]};
    fold2       = {16'd0, fold1[16]} + {1'b0, fold1[15:0]};
    calc        = ~fold2[15:0];
    rx          = {hdr[tcphp_pkg::CSUM_POS_HI], hdr[tcphp_pkg::CSUM_POS_LO]};
    long_enough = (total >= LENGTH_BITS'(tcphp_pkg::HDR_BYTES));
    pay_w       = PW'(total) - PW'(tcphp_pkg::HDR_BYTES);

    res = '0;
    if (long_enough) begin
      res.header_ok     = 1'b1;
      res.source_port   = {hdr[0], hdr[1]};
      res.dest_port     = {hdr[2], hdr[3]};
      res.seq_number    = {hdr[4], hdr[5], hdr[6], hdr[7]};
      res.ack_number    = {hdr[8], hdr[9], hdr[10], hdr[11]};
      res.flag_bits     = hdr[13];
      res.window_size   = {hdr[14], hdr[15]};
      res.received_sum  = rx;
      res.computed_sum  = calc;
      res.sum_match     = (rx == calc);
      res.payload_bytes = (pay_w > PW'(17'h0ffff)) ? 16'hffff : pay_w[15:0];
    end
  end

endmodule

>>> rtl/tcp_header_parse_checksum.sv
// ----------------------------------------------------------------------------
// tcp_header_parse_checksum
// Takes a TCP segment one byte per item, captures the fixed header, keeps a
// ones-complement checksum and reports one result per segment.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, set by the single accumulator add, while no
//   finished segment waits on a stalled result side. After the last byte is
//   accepted, the result passes input, segment snapshot and result registers.
// Reset: clears all valid flags, the byte count, the sum and the position
//   parity; header bytes need no clearing.
// ----------------------------------------------------------------------------
module tcp_header_parse_checksum #(
  parameter int LENGTH_BITS = tcphp_pkg::LENGTH_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  tcphp_in_if.sink    in_ch,
  tcphp_out_if.source out_ch
);

  localparam int HB = tcphp_pkg::HDR_BYTES;

  // input register
  logic        v1_r;
  logic [7:0]  byte1_r;
  logic        first1_r;
  logic        last1_r;
  logic [31:0] pseudo1_r;

  // running segment state
  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt;
  logic [31:0]            acc_r, acc_nxt;
  logic                   odd_r, odd_nxt;
  tcphp_pkg::hdr_t        hdr_r, hdr_nxt;

  // finished segment snapshot
  logic                   v2_r;
  logic [31:0]            acc2_r;
  logic [LENGTH_BITS-1:0] cnt2_r;
  tcphp_pkg::hdr_t        hdr2_r;

  // result register
  logic            vo_r;
  tcphp_pkg::res_t res_r;
  tcphp_pkg::res_t res_nxt;

  logic out_free, s2_go, s2_free, s1_go, s1_free;

  logic [LENGTH_BITS-1:0] pos;
  logic [31:0]            base_acc;
  logic                   base_odd;
  logic [31:0]            addend;
  logic [32:0]            sum33;

  assign out_free = !vo_r || out_ch.ready;
  assign s2_go    = v2_r && out_free;
  assign s2_free  = !v2_r || s2_go;
  assign s1_go    = v1_r && (!last1_r || s2_free);
  assign s1_free  = !v1_r || s1_go;

  assign in_ch.ready = s1_free;

  // segment state update for the byte in the input register
  always_comb begin
    pos      = first1_r ? '0 : cnt_r;
    base_acc = first1_r ? pseudo1_r : acc_r;
    base_odd = first1_r ? 1'b0 : odd_r;
    addend   = base_odd ? {24'd0, byte1_r} : {16'd0, byte1_r, 8'd0};
    sum33    = {1'b0, base_acc} + {1'b0, addend};
    if (pos == LENGTH_BITS'(tcphp_pkg::CSUM_POS_HI) ||
        pos == LENGTH_BITS'(tcphp_pkg::CSUM_POS_LO)) begin
      acc_nxt = base_acc;
    end else begin
      // end-around carry
      acc_nxt = sum33[31:0] + {31'd0, sum33[32]};
    end
    odd_nxt = !base_odd;
    cnt_nxt = (pos == '1) ? pos : pos + LENGTH_BITS'(1);
    for (int i = 0; i < HB; i++) begin
      hdr_nxt[i] = (pos == LENGTH_BITS'(i)) ? byte1_r : hdr_r[i];
    end
  end

  tcphp_result #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_result (
    .sum_acc (acc2_r),
    .total   (cnt2_r),
    .hdr     (hdr2_r),
    .res     (res_nxt)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      vo_r  <= 1'b0;
      cnt_r <= '0;
      acc_r <= '0;
      odd_r <= 1'b0;
    end else begin
      if (s1_free) v1_r <= in_ch.valid;
      if (s2_free) v2_r <= s1_go && last1_r;
      if (out_free) vo_r <= s2_go;
      if (s1_go) begin
        // restart after the last byte of a segment
        cnt_r <= last1_r ? '0 : cnt_nxt;
        acc_r <= last1_r ? '0 : acc_nxt;
        odd_r <= last1_r ? 1'b0 : odd_nxt;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ch.valid && s1_free) begin
      byte1_r   <= in_ch.data_byte;
      first1_r  <= in_ch.first_byte;
      last1_r   <= in_ch.last_byte;
      pseudo1_r <= in_ch.pseudo_sum;
    end
    if (s1_go) hdr_r <= hdr_nxt;
    if (s1_go && last1_r && s2_free) begin
      acc2_r <= acc_nxt;
      cnt2_r <= cnt_nxt;
      hdr2_r <= hdr_nxt;
    end
    if (s2_go) res_r <= res_nxt;
  end

  assign out_ch.valid         = vo_r;
  assign out_ch.header_ok     = res_r.header_ok;
  assign out_ch.source_port   = res_r.source_port;
  assign out_ch.dest_port     = res_r.dest_port;
  assign out_ch.seq_number    = res_r.seq_number;
  assign out_ch.ack_number    = res_r.ack_number;
  assign out_ch.flag_bits     = res_r.flag_bits;
  assign out_ch.window_size   = res_r.window_size;
  assign out_ch.received_sum  = res_r.received_sum;
  assign out_ch.computed_sum  = res_r.computed_sum;
  assign out_ch.sum_match     = res_r.sum_match;
  assign out_ch.payload_bytes = res_r.payload_bytes;

  // short segments report nothing but zeros
  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (vo_r && !res_r.header_ok) |-> (res_r.computed_sum == 16'd0 &&
      res_r.payload_bytes == 16'd0 && !res_r.sum_match &&
      res_r.source_port == 16'd0 && res_r.received_sum == 16'd0))
    else $error("short segment result not cleared");

  a_match: assert property (@(posedge clk) disable iff (!rst_n)
    (vo_r && res_r.header_ok) |->
      (res_r.sum_match == (res_r.received_sum == res_r.computed_sum)))
    else $error("sum_match disagrees with the checksums");

  a_snapshot_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_free && !(s1_go && last1_r)) |=> !v2_r)
    else $error("segment snapshot taken without a last byte");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!vo_r && !v2_r && !v1_r))
    else $error("pipeline not empty after reset");

endmodule

>>> dv/tcp_header_parse_checksum_tb.sv
// ----------------------------------------------------------------------------
// tcp_header_parse_checksum_tb
// Feeds TCP segments a byte at a time through the parser, with random gaps
// on the byte stream and random stalls on the result side. A model of the
// byte counter, ones-complement sum and header capture runs alongside and
// each result is checked field by field against it.
// ----------------------------------------------------------------------------
module tcp_header_parse_checksum_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEN_BITS     = tcphp_pkg::LENGTH_BITS_DEF;
  localparam int RANDOM_BYTES = 1200;

  typedef logic [7:0] seg_bytes_t[$];

  typedef struct {
    logic [7:0]  data;
    bit          first;
    bit          last;
    logic [31:0] psum;
  } seg_byte_t;

  bit   clk;
  logic rst_n;

  tcphp_in_if  in_ch ();
  tcphp_out_if out_ch ();

  tcp_header_parse_checksum dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Segment state as the block should hold it
  logic [LEN_BITS-1:0] seg_len;
  logic [31:0]         seg_sum;
  logic [7:0]          seg_hdr [tcphp_pkg::HDR_BYTES];
  bit                  seg_odd;

  tcphp_pkg::res_t pending_headers[$];
  int   mismatch_count;
  int   bytes_sent;
  int   burst_left;
  int   gap_limit;
  int   hold_request;
  int   hold_left  = 0;
  int   stall_mode = 0;
  int   stall_left = 0;

  function automatic logic [31:0] ones_add(logic [31:0] acc, logic [7:0] b, bit low_half);
    logic [32:0] wide;
    wide = {1'b0, acc} + (low_half ? {25'd0, b} : {17'd0, b, 8'd0});
    return wide[31:0] + {31'd0, wide[32]};
  endfunction

  function automatic logic [15:0] fold_invert(logic [31:0] s);
    while (s[31:16] != 16'd0)
      s = {16'd0, s[31:16]} + {16'd0, s[15:0]};
    return ~s[15:0];
  endfunction

  // Checksum a sender would place in bytes 16-17 of a segment
  function automatic logic [15:0] segment_checksum(logic [31:0] psum, seg_bytes_t q);
    logic [31:0] acc;
    acc = psum;
    foreach (q[i])
      if (i != tcphp_pkg::CSUM_POS_HI && i != tcphp_pkg::CSUM_POS_LO)
        acc = ones_add(acc, q[i], i[0]);
    return fold_invert(acc);
  endfunction

  function automatic void clear_segment_state();
    seg_len = '0;
    seg_sum = '0;
    seg_odd = 1'b0;
    foreach (seg_hdr[i])
      seg_hdr[i] = 8'd0;
  endfunction

  function automatic void track_segment_byte(seg_byte_t b);
    int unsigned     pos;
    int unsigned     pay;
    tcphp_pkg::res_t r;
    if (b.first) begin
      clear_segment_state();
      seg_sum = b.psum;
    end
    pos = 32'(seg_len);
    if (pos < tcphp_pkg::HDR_BYTES)
      seg_hdr[pos] = b.data;
    if (pos != tcphp_pkg::CSUM_POS_HI && pos != tcphp_pkg::CSUM_POS_LO)
      seg_sum = ones_add(seg_sum, b.data, seg_odd);
    seg_odd = !seg_odd;
    if (seg_len != '1)
      seg_len++;
    if (!b.last)
      return;
    r = '0;
    if (seg_len >= tcphp_pkg::HDR_BYTES) begin
      pay = 32'(seg_len) - tcphp_pkg::HDR_BYTES;
      r.header_ok     = 1'b1;
      r.source_port   = {seg_hdr[0], seg_hdr[1]};
      r.dest_port     = {seg_hdr[2], seg_hdr[3]};
      r.seq_number    = {seg_hdr[4], seg_hdr[5], seg_hdr[6], seg_hdr[7]};
      r.ack_number    = {seg_hdr[8], seg_hdr[9], seg_hdr[10], seg_hdr[11]};
      r.flag_bits     = seg_hdr[13];
      r.window_size   = {seg_hdr[14], seg_hdr[15]};
      r.received_sum  = {seg_hdr[tcphp_pkg::CSUM_POS_HI], seg_hdr[tcphp_pkg::CSUM_POS_LO]};
      r.computed_sum  = fold_invert(seg_sum);
      r.sum_match     = (r.received_sum == r.computed_sum);
      r.payload_bytes = (pay > 32'hffff) ? 16'hffff : pay[15:0];
    end
    pending_headers.push_back(r);
    clear_segment_state();
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on %s: expected %h, got %h", field, want, got);
    end
  endfunction

  // Send one byte, opening a random gap at the start of each burst
  task automatic send_byte(seg_byte_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(0, gap_limit);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b.data;
    in_ch.first_byte <= b.first;
    in_ch.last_byte  <= b.last;
    in_ch.pseudo_sum <= b.psum;
    @(posedge clk);
    while (!in_ch.ready)
      @(posedge clk);
    bytes_sent++;
    track_segment_byte(b);
  endtask

  task automatic send_segment(seg_bytes_t q, logic [31:0] psum, bit mark_first, bit mark_last);
    seg_byte_t b;
    foreach (q[i]) begin
      b.data  = q[i];
      b.first = mark_first && (i == 0);
      b.last  = mark_last && (i == q.size() - 1);
      b.psum  = (i == 0) ? psum : $urandom();  // ignored away from the first byte
      send_byte(b);
    end
  endtask

  function automatic seg_bytes_t random_bytes(int len);
    seg_bytes_t q;
    repeat (len) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  // Bytes without a first mark, straight after reset and after a last byte
  task automatic test_unmarked_start();
    gap_limit = 3;
    send_segment(random_bytes(20), 32'hdead_beef, 1'b0, 1'b1);
    send_segment(random_bytes(21), 32'h0123_4567, 1'b0, 1'b1);
  endtask

  task automatic test_short_segments();
    send_segment(random_bytes(1), 32'hffff_ffff, 1'b1, 1'b1);
    send_segment(random_bytes(2), $urandom(), 1'b1, 1'b1);
    send_segment(random_bytes(tcphp_pkg::HDR_BYTES - 1), $urandom(), 1'b1, 1'b1);
  endtask

  task automatic test_field_extremes();
    seg_bytes_t  q;
    logic [31:0] psum;
    logic [15:0] csum;
    q = {};
    repeat (tcphp_pkg::HDR_BYTES) q.push_back(8'h00);
    send_segment(q, 32'h0000_0000, 1'b1, 1'b1);
    // all ones with a full pseudo sum: end-around carry, odd last byte
    q = {};
    repeat (tcphp_pkg::HDR_BYTES + 1) q.push_back(8'hff);
    send_segment(q, 32'hffff_ffff, 1'b1, 1'b1);
    q = random_bytes(tcphp_pkg::HDR_BYTES + 3);
    psum = $urandom();
    csum = segment_checksum(psum, q);
    q[tcphp_pkg::CSUM_POS_HI] = csum[15:8];
    q[tcphp_pkg::CSUM_POS_LO] = csum[7:0];
    send_segment(q, psum, 1'b1, 1'b1);
    // abandon a segment midway and restart on a new first byte
    send_segment(random_bytes(9), $urandom(), 1'b1, 1'b0);
    send_segment(random_bytes(tcphp_pkg::HDR_BYTES), $urandom(), 1'b1, 1'b1);
  endtask

  // Hold the result side off while bytes keep coming, so the block backs up
  task automatic test_output_hold_off();
    gap_limit = 0;
    hold_request = 400;
    repeat (40)
      send_segment(random_bytes($urandom_range(1, 3)), $urandom(), 1'b1, 1'b1);
    repeat (4)
      send_segment(random_bytes(tcphp_pkg::HDR_BYTES), $urandom(), 1'b1, 1'b1);
  endtask

  task automatic test_random_segments();
    seg_bytes_t  q;
    logic [31:0] psum;
    logic [15:0] csum;
    seg_byte_t   b;
    int          stop_at;
    int          kind;
    int          len_pick;
    int          len;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      gap_limit = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      len_pick = $urandom_range(0, 9);
      if (len_pick < 2)
        len = $urandom_range(1, tcphp_pkg::HDR_BYTES - 1);
      else if (len_pick < 8)
        len = $urandom_range(tcphp_pkg::HDR_BYTES, 40);
      else if (len_pick == 8)
        len = $urandom_range(41, 120);
      else
        len = tcphp_pkg::HDR_BYTES;
      q = random_bytes(len);
      case ($urandom_range(0, 3))
        0:       psum = 32'hffff_ffff;
        1:       psum = 32'h0000_0000;
        default: psum = $urandom();
      endcase
      if (len >= tcphp_pkg::HDR_BYTES && $urandom_range(0, 1)) begin
        csum = segment_checksum(psum, q);
        q[tcphp_pkg::CSUM_POS_HI] = csum[15:8];
        q[tcphp_pkg::CSUM_POS_LO] = csum[7:0];
      end
      kind = $urandom_range(0, 99);
      if (kind < 80)
        send_segment(q, psum, 1'b1, 1'b1);
      else if (kind < 88)
        send_segment(q, psum, 1'b0, 1'b1);
      else if (kind < 95)
        send_segment(q, psum, 1'b1, 1'b0);
      else begin
        foreach (q[i]) begin
          b.data  = q[i];
          b.first = ($urandom_range(0, 3) == 0);
          b.last  = ($urandom_range(0, 3) == 0);
          b.psum  = $urandom();
          send_byte(b);
        end
      end
    end
  endtask

  // Result side: long hold-off on request, otherwise a changing stall pattern
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (rst_n !== 1'b1) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(16, 128);
      end
      stall_left--;
      case (stall_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
        2:       out_ch.ready <= ($urandom_range(0, 9) < 3);
        default: out_ch.ready <= ~out_ch.ready;
      endcase
    end
  end

  always @(posedge clk) begin
    tcphp_pkg::res_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_headers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result with none expected: source_port %h", out_ch.source_port);
      end else begin
        want = pending_headers.pop_front();
        check_field("header_ok", 32'(want.header_ok), 32'(out_ch.header_ok));
        check_field("source_port", 32'(want.source_port), 32'(out_ch.source_port));
        check_field("dest_port", 32'(want.dest_port), 32'(out_ch.dest_port));
        check_field("seq_number", want.seq_number, out_ch.seq_number);
        check_field("ack_number", want.ack_number, out_ch.ack_number);
        check_field("flag_bits", 32'(want.flag_bits), 32'(out_ch.flag_bits));
        check_field("window_size", 32'(want.window_size), 32'(out_ch.window_size));
        check_field("received_sum", 32'(want.received_sum), 32'(out_ch.received_sum));
        check_field("computed_sum", 32'(want.computed_sum), 32'(out_ch.computed_sum));
        check_field("sum_match", 32'(want.sum_match), 32'(out_ch.sum_match));
        check_field("payload_bytes", 32'(want.payload_bytes), 32'(out_ch.payload_bytes));
      end
    end
  end

  initial begin
    int drain_cycles;
    clear_segment_state();
    mismatch_count   = 0;
    bytes_sent       = 0;
    burst_left       = 0;
    gap_limit        = 3;
    hold_request     = 0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= 8'd0;
    in_ch.first_byte <= 1'b0;
    in_ch.last_byte  <= 1'b0;
    in_ch.pseudo_sum <= 32'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unmarked_start();
    test_short_segments();
    test_field_extremes();
    test_output_hold_off();
    test_random_segments();

    in_ch.valid <= 1'b0;
    drain_cycles = 0;
    while (pending_headers.size() != 0 && drain_cycles < 200000) begin
      @(posedge clk);
      drain_cycles++;
    end
    if (pending_headers.size() != 0) begin
      $display("tcp_header_parse_checksum_tb NOT OK");
      $finish;
    end else begin
      repeat (10) @(posedge clk);
      if (mismatch_count == 0 && pending_headers.size() == 0)
        $display("tcp_header_parse_checksum_tb OK");
      else
        $display("tcp_header_parse_checksum_tb NOT OK");
      $finish;
    end
  end

  initial begin
    #40ms;
    $display("tcp_header_parse_checksum_tb NOT OK");
    $finish;
  end

endmodule
